@@ rtl/lad_pkg.sv @@
// Shared types and constants for the linear array deque.
package lad_pkg;

   localparam int LAD_DEPTH_DEFAULT = 8;
   // Widest slot index at the largest supported depth (64).
   localparam int LAD_IDX_MAX_W     = 6;
   localparam int LAD_DATA_W        = 32;
   localparam int LAD_QUEUE_DEPTH   = 2;

   typedef enum logic [2:0] {
      CMD_INS_REAR  = 3'd0,
      CMD_DEL_FRONT = 3'd1,
      CMD_INS_FRONT = 3'd2,
      CMD_DEL_REAR  = 3'd3,
      CMD_LIST      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FRONT0 = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_STATUS = 2'd0,
      OP_WRITE  = 2'd1,
      OP_READ   = 2'd2,
      OP_LIST   = 2'd3
   } op_kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_WORK = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [2:0]                   command;
      logic signed [LAD_DATA_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic signed [LAD_DATA_W-1:0] data_out;
      logic                         last;
   } rsp_type;

   // One classified operation handed from front to back.
   typedef struct packed {
      op_kind_type              kind;
      status_type               status;
      logic [LAD_IDX_MAX_W-1:0] addr;
      logic [LAD_IDX_MAX_W-1:0] stop;
      logic [LAD_DATA_W-1:0]    data;
   } op_type;

   // Result waiting for the registered RAM read.
   typedef struct packed {
      logic       valid;
      logic       rd;
      status_type status;
      logic       last;
   } pend_type;

endpackage

@@ rtl/lad_ram.sv @@
// Generic simple dual-port RAM with registered read.
module lad_ram
   import lad_pkg::*;
#(
   parameter int WIDTH = LAD_DATA_W,
   parameter int DEPTH = LAD_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lad_queue.sv @@
// Short queue of classified operations between front and back.
module lad_queue
   import lad_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output op_type head_op,
   output logic   full,
   output logic   empty
);

   localparam int PTR_W = $clog2(LAD_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(LAD_QUEUE_DEPTH + 1);

   op_type             entry_ff [LAD_QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_W'(LAD_QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(LAD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(LAD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("operation queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("operation queue underflow");

endmodule

@@ rtl/lad_front.sv @@
// Command front end: tracks head, tail and empty flag and classifies commands.
module lad_front
   import lad_pkg::*;
#(
   parameter int DEPTH = LAD_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    push,
   output op_type  push_op
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             empty_ff, empty_in;

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      empty_in       = empty_ff;
      push           = 1'b0;
      push_op.kind   = OP_STATUS;
      push_op.status = ST_OK;
      push_op.addr   = LAD_IDX_MAX_W'(head_ff);
      push_op.stop   = LAD_IDX_MAX_W'(tail_ff);
      push_op.data   = req.data_in;
      if (accept) begin
         unique case (req.command)
            CMD_INS_REAR: begin
               push = 1'b1;
               if (empty_ff) begin
                  head_in      = '0;
                  tail_in      = '0;
                  empty_in     = 1'b0;
                  push_op.kind = OP_WRITE;
                  push_op.addr = '0;
               end else if (tail_ff == IDX_W'(DEPTH - 1)) begin
                  push_op.status = ST_FULL;
               end else begin
                  tail_in      = tail_ff + 1'b1;
                  push_op.kind = OP_WRITE;
                  push_op.addr = LAD_IDX_MAX_W'(tail_in);
               end
            end
            CMD_INS_FRONT: begin
               push = 1'b1;
               if (empty_ff) begin
                  head_in      = '0;
                  tail_in      = '0;
                  empty_in     = 1'b0;
                  push_op.kind = OP_WRITE;
                  push_op.addr = '0;
               end else if (head_ff == '0) begin
                  push_op.status = ST_FRONT0;
               end else begin
                  head_in      = head_ff - 1'b1;
                  push_op.kind = OP_WRITE;
                  push_op.addr = LAD_IDX_MAX_W'(head_in);
               end
            end
            CMD_DEL_FRONT, CMD_DEL_REAR: begin
               push = 1'b1;
               if (empty_ff) begin
                  push_op.status = ST_EMPTY;
               end else begin
                  push_op.kind = OP_READ;
                  push_op.addr = (req.command == CMD_DEL_FRONT) ?
                                 LAD_IDX_MAX_W'(head_ff) : LAD_IDX_MAX_W'(tail_ff);
                  if (head_ff == tail_ff) begin
                     head_in  = '0;
                     tail_in  = '0;
                     empty_in = 1'b1;
                  end else if (req.command == CMD_DEL_FRONT) begin
                     head_in = head_ff + 1'b1;
                  end else begin
                     tail_in = tail_ff - 1'b1;
                  end
               end
            end
            CMD_LIST: begin
               push = 1'b1;
               if (empty_ff || (head_ff > tail_ff)) begin
                  push_op.status = ST_EMPTY;
               end else begin
                  push_op.kind = OP_LIST;
               end
            end
            default: begin
               // drop unknown commands: no result, no state change
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   a_empty_at_zero: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty queue with nonzero indices");

   a_ordered: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (head_ff <= tail_ff))
      else $error("head index passed tail index");

endmodule

@@ rtl/lad_back.sv @@
// Execution back end: performs slot writes and reads and emits the results.
module lad_back
   import lad_pkg::*;
#(
   parameter int DEPTH = LAD_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  op_type  head_op,
   input  logic    q_empty,
   output logic    pop,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int IDX_W = $clog2(DEPTH);

   back_state_type        state_ff, state_in;
   op_type                cur_ff, cur_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   pend_type              pend_ff, pend_in;

   logic                  wr_en;
   logic                  rd_en;
   logic [LAD_DATA_W-1:0] rd_data;

   lad_ram #(
      .WIDTH (LAD_DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (cur_ff.data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      addr_in        = addr_ff;
      pop            = 1'b0;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      pend_in.valid  = 1'b0;
      pend_in.rd     = 1'b0;
      pend_in.status = ST_OK;
      pend_in.last   = 1'b1;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               cur_in   = head_op;
               addr_in  = head_op.addr[IDX_W-1:0];
               state_in = BK_WORK;
            end
         end
         BK_WORK: begin
            pend_in.valid  = 1'b1;
            pend_in.status = cur_ff.status;
            state_in       = BK_IDLE;
            unique case (cur_ff.kind)
               OP_STATUS: ;
               OP_WRITE:  wr_en = 1'b1;
               OP_READ: begin
                  rd_en      = 1'b1;
                  pend_in.rd = 1'b1;
               end
               OP_LIST: begin
                  // advance one slot per cycle until the tail
                  rd_en        = 1'b1;
                  pend_in.rd   = 1'b1;
                  pend_in.last = (addr_ff == cur_ff.stop[IDX_W-1:0]);
                  if (!pend_in.last) begin
                     addr_in  = addr_ff + 1'b1;
                     state_in = BK_WORK;
                  end
               end
               default: ;
            endcase
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         pend_ff.valid <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff.valid <= pend_in.valid;
      end
      cur_ff         <= cur_in;
      addr_ff        <= addr_in;
      pend_ff.rd     <= pend_in.rd;
      pend_ff.status <= pend_in.status;
      pend_ff.last   <= pend_in.last;
   end

   assign rsp_valid            = pend_ff.valid;
   assign rsp_payload.status   = pend_ff.status;
   assign rsp_payload.data_out = pend_ff.rd ? rd_data : '0;
   assign rsp_payload.last     = pend_ff.last;

   a_read_issued: assert property (@(posedge clock) disable iff (reset)
      (pend_ff.valid && pend_ff.rd) |-> $past(rd_en))
      else $error("read result without a slot read");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == BK_IDLE && !q_empty))
      else $error("pop outside idle state");

endmodule

@@ rtl/linear_array_deque_top.sv @@
// A result appears on rsp_ once a request taken with the back end idle has passed the queue,
// the back end's operation register and the pending-result register. The back end runs one
// operation at a time; a list reads one slot per cycle from the single-read slot RAM.
// busy rises while the two-entry operation queue is full; results cannot be stalled.
// Reset clears head, tail, empty flag, queue and back end; slot contents are not cleared.
module linear_array_deque_top
   import lad_pkg::*;
#(
   parameter int DEPTH = LAD_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   logic   accept;
   logic   push;
   op_type push_op;
   logic   pop;
   op_type head_op;
   logic   q_full;
   logic   q_empty;

   assign busy   = q_full;
   assign accept = start && !busy;

   lad_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_payload),
      .push    (push),
      .push_op (push_op)
   );

   lad_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .full    (q_full),
      .empty   (q_empty)
   );

   lad_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_op     (head_op),
      .q_empty     (q_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
